/* hw/rtl/tls_pkg.sv */
// shared types and constants for the traffic light sequencer
package tls_pkg;

    localparam int unsigned LightW = 10;
    localparam int unsigned TimeW  = 16;
    localparam int unsigned TickW  = 32;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [2:0] {
        PH_RED     = 3'd0,
        PH_YELLOW1 = 3'd1,
        PH_GREEN   = 3'd2,
        PH_FLASH   = 3'd3,
        PH_YELLOW2 = 3'd4,
        PH_NIGHT   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        COL_OFF    = 2'd0,
        COL_RED    = 2'd1,
        COL_YELLOW = 2'd2,
        COL_GREEN  = 2'd3
    } t_colour;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DARK   = 3'd0,
        CFG_RED    = 3'd1,
        CFG_YELLOW = 3'd2,
        CFG_GREEN  = 3'd3,
        CFG_FLASH  = 3'd4,
        CFG_BLINK  = 3'd5,
        CFG_EXTEND = 3'd6
    } t_cfg_idx;

    localparam logic [LightW-1:0] DarkReset   = 10'd300;
    localparam logic [TimeW-1:0]  RedReset    = 16'd7000;
    localparam logic [TimeW-1:0]  YellowReset = 16'd3000;
    localparam logic [TimeW-1:0]  GreenReset  = 16'd5000;
    localparam logic [TimeW-1:0]  FlashReset  = 16'd2000;
    localparam logic [TimeW-1:0]  BlinkReset  = 16'd500;
    localparam logic [TimeW-1:0]  ExtendReset = 16'd5000;

endpackage

/* hw/rtl/traffic_light_sequencer_unit.sv */
// traffic light sequencer: tick-driven phase sequencer with night blinking
// a tick beat passes the input register, then the next-state logic, and its result beat leaves from the result register
// throughput: one tick beat per cycle while the consumer keeps taking results, set by the single-pass next-state logic
// an input register and a result register part the two channels, so a tick is still
// taken into an empty input register while an earlier result waits for the consumer
// synchronous active-low reset restores the register defaults and night mode
module traffic_light_sequencer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_button_level,
    input  logic                           i_motion_level,
    input  logic [tls_pkg::LightW-1:0]     i_light_sample,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_lamp_colour,
    output logic                           o_lamp_written,
    output logic [2:0]                     o_phase,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [tls_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [tls_pkg::TimeW-1:0]      i_cfg_data
);
    import tls_pkg::*;

    // configuration registers
    logic [LightW-1:0] r_dark;
    logic [TimeW-1:0]  r_red_time, r_yellow_time, r_green_time;
    logic [TimeW-1:0]  r_flash_time, r_blink_half, r_extend_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark        <= DarkReset;
            r_red_time    <= RedReset;
            r_yellow_time <= YellowReset;
            r_green_time  <= GreenReset;
            r_flash_time  <= FlashReset;
            r_blink_half  <= BlinkReset;
            r_extend_time <= ExtendReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DARK:   r_dark        <= i_cfg_data[LightW-1:0];
                CFG_RED:    r_red_time    <= i_cfg_data;
                CFG_YELLOW: r_yellow_time <= i_cfg_data;
                CFG_GREEN:  r_green_time  <= i_cfg_data;
                CFG_FLASH:  r_flash_time  <= i_cfg_data;
                CFG_BLINK:  r_blink_half  <= i_cfg_data;
                CFG_EXTEND: r_extend_time <= i_cfg_data;
                default: ; // index beyond the register list is dropped
            endcase
        end
    end

    // input register stage
    logic              r_in_valid;
    logic              r_btn, r_mot;
    logic [LightW-1:0] r_light;
    logic              advance;

    // result register frees up when empty or being drained this cycle
    assign advance = !o_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_btn   <= i_button_level;
            r_mot   <= i_motion_level;
            r_light <= i_light_sample;
        end
    end

    // sequencer state
    logic [TickW-1:0] r_tick, r_phase_dl, r_blink_dl;
    t_phase           r_phase;
    t_colour          r_colour;
    logic             r_entry, r_day, r_lit, r_btn_prev, r_mot_prev;

    logic [TickW-1:0] n_phase_dl, n_blink_dl;
    t_phase           n_phase;
    t_colour          n_colour;
    logic             n_entry, n_day, n_lit, n_wrote;

    logic             press, motion;
    logic             blink_en;
    t_colour          blink_col;
    logic [TickW-1:0] now;

    assign now    = r_tick;
    assign press  = r_btn && !r_btn_prev;
    assign motion = r_mot && !r_mot_prev;

    always_comb begin
        n_phase_dl = r_phase_dl;
        n_blink_dl = r_blink_dl;
        n_phase    = r_phase;
        n_colour   = r_colour;
        n_entry    = r_entry;
        n_day      = r_day;
        n_lit      = r_lit;
        n_wrote    = 1'b0;
        blink_en   = 1'b0;
        blink_col  = COL_YELLOW;

        // day / night selection from the light sample
        if (r_light < r_dark) begin
            if (r_day) begin
                n_day      = 1'b0;
                n_blink_dl = '0;
                n_lit      = 1'b0;
            end
        end else if (!r_day) begin
            n_phase = PH_RED;
            n_entry = 1'b1;
            n_day   = 1'b1;
        end

        if (n_day) begin
            unique case (n_phase) inside
                PH_RED: begin
                    if (n_entry) begin
                        n_colour   = COL_RED;
                        n_wrote    = 1'b1;
                        n_entry    = 1'b0;
                        n_phase_dl = now + {{(TickW-TimeW){1'b0}}, r_red_time};
                    end else if (now >= n_phase_dl || press) begin
                        n_phase = PH_YELLOW1;
                        n_entry = 1'b1;
                    end
                    // motion holds red longer
                    if (motion) begin
                        n_phase_dl = n_phase_dl + {{(TickW-TimeW){1'b0}}, r_extend_time};
                    end
                end
                PH_YELLOW1, PH_YELLOW2: begin
                    if (n_entry) begin
                        n_colour   = COL_YELLOW;
                        n_wrote    = 1'b1;
                        n_entry    = 1'b0;
                        n_phase_dl = now + {{(TickW-TimeW){1'b0}}, r_yellow_time};
                    end
                    // deadline also checked on the entry tick
                    if (now >= n_phase_dl) begin
                        n_phase = (n_phase == PH_YELLOW1) ? PH_GREEN : PH_RED;
                        n_entry = 1'b1;
                    end
                end
                PH_GREEN: begin
                    if (n_entry) begin
                        n_colour   = COL_GREEN;
                        n_wrote    = 1'b1;
                        n_entry    = 1'b0;
                        n_phase_dl = now + {{(TickW-TimeW){1'b0}}, r_green_time};
                    end else if (now >= n_phase_dl) begin
                        n_phase = PH_FLASH;
                        n_entry = 1'b1;
                    end
                    // button extends green, motion cuts straight to yellow
                    if (press) begin
                        n_phase_dl = n_phase_dl + {{(TickW-TimeW){1'b0}}, r_extend_time};
                    end else if (motion) begin
                        n_phase = PH_YELLOW2;
                        n_entry = 1'b1;
                    end
                end
                PH_FLASH: begin
                    if (n_entry) begin
                        n_entry    = 1'b0;
                        n_phase_dl = now + {{(TickW-TimeW){1'b0}}, r_flash_time};
                    end else if (now >= n_phase_dl) begin
                        n_phase = PH_YELLOW2;
                        n_entry = 1'b1;
                    end
                    // blink timer carries over, not restarted on entry
                    blink_en  = 1'b1;
                    blink_col = COL_GREEN;
                end
                default: ; // unused phase codes do nothing
            endcase
        end else begin
            blink_en  = 1'b1;
            blink_col = COL_YELLOW;
        end

        // shared blink timer
        if (blink_en && now >= n_blink_dl) begin
            n_blink_dl = now + {{(TickW-TimeW){1'b0}}, r_blink_half};
            n_wrote    = 1'b1;
            if (n_lit) begin
                n_colour = COL_OFF;
                n_lit    = 1'b0;
            end else begin
                n_colour = blink_col;
                n_lit    = 1'b1;
            end
        end
    end

    logic step;
    assign step = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_phase_dl <= '0;
            r_blink_dl <= '0;
            r_phase    <= PH_RED;
            r_colour   <= COL_OFF;
            r_entry    <= 1'b0;
            r_day      <= 1'b0;
            r_lit      <= 1'b0;
            r_btn_prev <= 1'b0;
            r_mot_prev <= 1'b0;
        end else if (step) begin
            r_tick     <= now + 1'b1;
            r_phase_dl <= n_phase_dl;
            r_blink_dl <= n_blink_dl;
            r_phase    <= n_phase;
            r_colour   <= n_colour;
            r_entry    <= n_entry;
            r_day      <= n_day;
            r_lit      <= n_lit;
            r_btn_prev <= r_btn;
            r_mot_prev <= r_mot;
        end
    end

    // result register
    logic       r_out_valid;
    logic [1:0] r_out_colour;
    logic       r_out_written;
    logic [2:0] r_out_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_colour  <= n_colour;
            r_out_written <= n_wrote;
            r_out_phase   <= n_day ? n_phase : PH_NIGHT;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_lamp_colour  = r_out_colour;
    assign o_lamp_written = r_out_written;
    assign o_phase        = r_out_phase;

endmodule
